// ----- rtl/tsc_pkg.sv -----
package tsc_pkg;

  localparam int unsigned NUM_TERMS_DEF       = 8;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 24;

  localparam int unsigned ANGLE_W   = 32;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned WORK_FRAC = 29;
  localparam int unsigned X_W       = 32;       // reduced angle, Q3.29
  localparam int unsigned RED_W     = 34;       // range reduction word
  localparam int unsigned TERM_W    = 34;       // terms and x^2
  localparam int unsigned SUM_W     = TERM_W + 2;
  localparam int unsigned K_W       = 32;
  localparam int unsigned K_SHIFT   = 32;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

  localparam logic [0:0] OP_SINE   = 1'b0;
  localparam logic [0:0] OP_COSINE = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic signed [X_W-1:0] x;
  } tsc_entry_t;

  // pi scaled by 2^(62-drop), rounded to nearest
  function automatic logic [63:0] angle_const(input int unsigned drop);
    return (PI_Q62 + (64'd1 << (drop - 1))) >> drop;
  endfunction

endpackage

// ----- rtl/taylor_sine_cosine.sv -----
// Sine or cosine of a signed fixed-point angle (radians) by a Taylor series,
// result in signed Q2.30 saturated to +-1.0. Cosine is taken as the sine of
// the angle plus pi/2. One request is accepted per clock while in_stall_o is
// low; the front reduces the angle modulo 2*pi with a pipelined compare/subtract
// remainder search (30 - ANGLE_FRAC_BITS steps), a four-entry queue decouples
// it from the back, which evaluates the series with two pipelined multiplies
// per term. Either side may stall without losing requests.
module taylor_sine_cosine import tsc_pkg::*; #(
  parameter int unsigned NUM_TERMS       = NUM_TERMS_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] value_o
);

  tsc_entry_t push, head;
  logic       full, pop;

  tsc_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .angle_i,
    .push_o(push), .full_i(full)
  );

  tsc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .pop_i(pop), .head_o(head)
  );

  tsc_back #(.NUM_TERMS(NUM_TERMS)) u_back (
    .clk_i, .rst_ni, .head_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i, .value_o
  );

endmodule

// ----- rtl/tsc_front.sv -----
module tsc_front import tsc_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output tsc_entry_t                push_o,
  input  logic                      full_i
);

  localparam int unsigned M  = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int unsigned Q  = M + 1;                   // quotient bits
  localparam int unsigned SH = WORK_FRAC - ANGLE_FRAC_BITS;

  localparam logic [RED_W-1:0] PI_A      = RED_W'(angle_const(62 - ANGLE_FRAC_BITS));
  localparam logic [RED_W-1:0] TWO_PI_A  = RED_W'(angle_const(61 - ANGLE_FRAC_BITS));
  localparam logic [RED_W-1:0] HALF_PI_A = RED_W'(angle_const(63 - ANGLE_FRAC_BITS));
  // bias by a multiple of 2*pi so the remainder search runs on a positive value
  localparam logic [RED_W-1:0] BIAS      = RED_W'(TWO_PI_A << M);
  localparam logic [RED_W-1:0] BIAS_COS  = RED_W'(BIAS + HALF_PI_A);

  logic               en;
  logic [Q:0]         v_q;
  logic [RED_W-1:0]   rem_q [Q+1];
  logic [RED_W-1:0]   rem_d [Q+1];
  logic               xv_q;
  logic signed [X_W-1:0] x_q, x_d;
  logic [RED_W-1:0]   r_fold;
  logic [RED_W-1:0]   r_shift;

  assign en         = !(xv_q && full_i);
  assign in_stall_o = !en;

  always_comb begin
    rem_d[0] = {{(RED_W-ANGLE_W){angle_i[ANGLE_W-1]}}, angle_i} +
               ((operation_i == OP_COSINE) ? BIAS_COS : BIAS);
    for (int s = 1; s <= Q; s++) begin
      if (rem_q[s-1] >= RED_W'(TWO_PI_A << (Q - s))) begin
        rem_d[s] = rem_q[s-1] - RED_W'(TWO_PI_A << (Q - s));
      end else begin
        rem_d[s] = rem_q[s-1];
      end
    end
  end

  always_comb begin
    r_fold  = (rem_q[Q] > PI_A) ? rem_q[Q] - TWO_PI_A : rem_q[Q];
    r_shift = r_fold << SH;
    x_d     = r_shift[X_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      xv_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[Q-1:0], in_valid_i};
      xv_q <= v_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s <= Q; s++) begin
        rem_q[s] <= rem_d[s];
      end
      x_q <= x_d;
    end
  end

  assign push_o.valid = xv_q && !full_i;
  assign push_o.x     = x_q;

endmodule

// ----- rtl/tsc_queue.sv -----
module tsc_queue import tsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tsc_entry_t push_i,
  output logic       full_o,
  input  logic       pop_i,
  output tsc_entry_t head_o
);

  logic signed [X_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_q, rd_q;
  logic [QCNT_W-1:0]     cnt_q, cnt_d;
  logic                  push, pop;

  assign push   = push_i.valid;
  assign pop    = pop_i && (cnt_q != '0);
  assign full_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.x     = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_i.x;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push) else $error("push into full queue");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count not incremented");
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 1'b1) else $error("count not decremented");

endmodule

// ----- rtl/tsc_back.sv -----
module tsc_back import tsc_pkg::*; #(
  parameter int unsigned NUM_TERMS = NUM_TERMS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tsc_entry_t                head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] value_o
);

  localparam logic signed [SUM_W:0] ONE_P = (SUM_W+1)'(64'sd1 <<< 30);
  localparam logic signed [SUM_W:0] ONE_N = -ONE_P;

  logic en;
  logic                     vx_q;
  logic signed [X_W-1:0]    x_q;
  logic signed [2*X_W-1:0]  xx;
  // stage B of term n (index 0 holds x itself)
  logic [NUM_TERMS:0]         vb_q;
  logic signed [TERM_W-1:0]   term_q [NUM_TERMS+1];
  logic signed [TERM_W-1:0]   term_d [NUM_TERMS+1];
  logic signed [TERM_W-1:0]   x2_q   [NUM_TERMS+1];
  logic signed [SUM_W-1:0]    sum_q  [NUM_TERMS+1];
  // stage A of term n
  logic [NUM_TERMS-1:0]       va_q;
  logic signed [TERM_W-1:0]   t_q    [NUM_TERMS];
  logic signed [TERM_W-1:0]   t_d    [NUM_TERMS];
  logic signed [TERM_W-1:0]   x2a_q  [NUM_TERMS];
  logic signed [SUM_W-1:0]    suma_q [NUM_TERMS];
  logic                       out_v_q;
  logic signed [VALUE_W-1:0]  value_q;
  logic signed [SUM_W-1:0]    fin;
  logic signed [SUM_W:0]      dbl;
  logic signed [VALUE_W-1:0]  sat;

  assign en    = !out_v_q || !out_stall_i;
  assign pop_o = en && head_i.valid;

  assign xx        = x_q * x_q;
  assign term_d[0] = TERM_W'(x_q);

  for (genvar n = 1; n <= NUM_TERMS; n++) begin : g_term
    localparam longint D = longint'(2 * n) * longint'(2 * n + 1);
    localparam longint K = ((longint'(1) <<< 32) + D / 2) / D;
    localparam logic signed [K_W-1:0] KC = K_W'(K);
    logic signed [TERM_W:0]       neg;
    logic signed [TERM_W+K_W:0]   pa;
    logic signed [2*TERM_W-1:0]   pb;
    assign neg = -{term_q[n-1][TERM_W-1], term_q[n-1]};
    assign pa  = neg * KC;
    assign t_d[n-1] = pa[K_SHIFT+TERM_W-1:K_SHIFT];
    assign pb  = t_q[n-1] * x2a_q[n-1];
    assign term_d[n] = pb[WORK_FRAC+TERM_W-1:WORK_FRAC];
  end

  always_comb begin
    fin = sum_q[NUM_TERMS] + SUM_W'(term_q[NUM_TERMS]);
    dbl = {fin, 1'b0};
    if (dbl > ONE_P) begin
      sat = VALUE_W'(ONE_P);
    end else if (dbl < ONE_N) begin
      sat = VALUE_W'(ONE_N);
    end else begin
      sat = dbl[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q    <= 1'b0;
      vb_q    <= '0;
      va_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vx_q    <= head_i.valid;
      vb_q[0] <= vx_q;
      for (int n = 1; n <= NUM_TERMS; n++) begin
        va_q[n-1] <= vb_q[n-1];
        vb_q[n]   <= va_q[n-1];
      end
      out_v_q <= vb_q[NUM_TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q       <= head_i.x;
      term_q[0] <= term_d[0];
      x2_q[0]   <= xx[WORK_FRAC+TERM_W-1:WORK_FRAC];
      sum_q[0]  <= '0;
      for (int n = 1; n <= NUM_TERMS; n++) begin
        t_q[n-1]    <= t_d[n-1];
        x2a_q[n-1]  <= x2_q[n-1];
        suma_q[n-1] <= sum_q[n-1] + SUM_W'(term_q[n-1]);
        term_q[n]   <= term_d[n];
        x2_q[n]     <= x2a_q[n-1];
        sum_q[n]    <= suma_q[n-1];
      end
      value_q <= sat;
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = value_q;

endmodule
